/* hdl/oaht_pkg.sv */
`default_nettype none

package oaht_pkg;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned HomeShift  = 4;
  localparam int unsigned ProbeStride = 39;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO_KEY  = 3'd4
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    clear_en;
    logic    load;
    logic    step;
    logic    ins;
    logic    fin;
    status_e code;
  } oaht_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic is_search;
    logic zero_key;
    logic table_full;
    logic slot_empty;
    logic key_match;
    logic probe_last;
  } oaht_stat_t;

endpackage

`default_nettype wire

/* hdl/oaht_dp.sv */
`default_nettype none

module oaht_dp #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  oaht_pkg::oaht_cmd_t  cmd_i,
  output oaht_pkg::oaht_stat_t stat_o,
  input  wire                  kind_i,
  input  wire  [31:0]          key_i,
  input  wire  [31:0]          value_i,
  output logic                 done_o,
  output logic [2:0]           status_o,
  output logic [31:0]          found_value_o
);
  import oaht_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] HalfDepth = CW'(TABLE_DEPTH / 2);
  localparam logic [AW-1:0] Stride = AW'(ProbeStride);

  logic [KeyWidth-1:0]   key_mem [TABLE_DEPTH];
  logic [ValueWidth-1:0] val_mem [TABLE_DEPTH];

  logic                  kind_q;
  logic [KeyWidth-1:0]   key_q;
  logic [ValueWidth-1:0] value_q;
  logic [AW-1:0]         slot_q, slot_d;
  logic [AW-1:0]         probe_q, probe_d;
  logic [AW-1:0]         clr_ptr_q;
  logic [CW-1:0]         count_q;
  logic [KeyWidth-1:0]   rd_key_q;
  logic [ValueWidth-1:0] rd_val_q;
  logic                  done_q;
  status_e               status_q;
  logic [ValueWidth-1:0] found_q;

  logic                  key_we;
  logic [AW-1:0]         key_wa;
  logic [KeyWidth-1:0]   key_wd;

  // the key store has one write port, shared by the clearing pass and inserts
  assign key_we = cmd_i.clear_en | cmd_i.ins;
  assign key_wa = cmd_i.clear_en ? clr_ptr_q : slot_q;
  assign key_wd = cmd_i.clear_en ? '0 : key_q;

  always_comb begin
    slot_d  = slot_q;
    probe_d = probe_q;
    if (cmd_i.load) begin
      slot_d  = key_i[HomeShift +: AW];
      probe_d = '0;
    end else if (cmd_i.step) begin
      slot_d  = slot_q + Stride;
      probe_d = probe_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    rd_key_q <= key_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      val_mem[slot_q] <= value_q;
    end
    rd_val_q <= val_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    slot_q  <= slot_d;
    probe_q <= probe_d;
    if (cmd_i.fin) begin
      status_q <= cmd_i.code;
      found_q  <= (cmd_i.code == ST_FOUND) ? rd_val_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_ptr_q <= clr_ptr_q + AW'(1);
      end
      if (cmd_i.ins) begin
        count_q <= count_q + CW'(1);
      end
      done_q <= cmd_i.fin;
    end
  end

  assign stat_o.clr_last   = &clr_ptr_q;
  assign stat_o.is_search  = (kind_q == KIND_SEARCH);
  assign stat_o.zero_key   = (key_q == '0);
  assign stat_o.table_full = (count_q > HalfDepth);
  assign stat_o.slot_empty = (rd_key_q == '0);
  assign stat_o.key_match  = (rd_key_q == key_q);
  assign stat_o.probe_last = &probe_q;

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;

  // an insert only ever fills an empty slot
  a_ins_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins |-> (rd_key_q == '0) && !stat_o.is_search)
    else $error("insert into an occupied slot");

  // the half-full limit bounds the fill
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= HalfDepth + CW'(1))
    else $error("entry count beyond half-full limit");

  // results are never back to back
  a_done_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobes in consecutive cycles");

endmodule

`default_nettype wire

/* hdl/oaht_ctrl.sv */
`default_nettype none

module oaht_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  oaht_pkg::oaht_stat_t stat_i,
  output oaht_pkg::oaht_cmd_t  cmd_o
);
  import oaht_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RD    = 4'b0100,
    S_CMP   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.code     = ST_NOT_FOUND;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        // rejected inserts finish while the first read is still in flight
        if (!stat_i.is_search && stat_i.zero_key) begin
          cmd_o.fin  = 1'b1;
          cmd_o.code = ST_ZERO_KEY;
          state_d    = S_IDLE;
        end else if (!stat_i.is_search && stat_i.table_full) begin
          cmd_o.fin  = 1'b1;
          cmd_o.code = ST_FULL;
          state_d    = S_IDLE;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.is_search) begin
          if (stat_i.slot_empty) begin
            cmd_o.fin  = 1'b1;
            cmd_o.code = ST_NOT_FOUND;
            state_d    = S_IDLE;
          end else if (stat_i.key_match) begin
            cmd_o.fin  = 1'b1;
            cmd_o.code = ST_FOUND;
            state_d    = S_IDLE;
          end else if (stat_i.probe_last) begin
            cmd_o.fin  = 1'b1;
            cmd_o.code = ST_NOT_FOUND;
            state_d    = S_IDLE;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = S_RD;
          end
        end else begin
          if (stat_i.slot_empty) begin
            cmd_o.ins  = 1'b1;
            cmd_o.fin  = 1'b1;
            cmd_o.code = ST_INSERTED;
            state_d    = S_IDLE;
          end else if (stat_i.probe_last) begin
            cmd_o.fin  = 1'b1;
            cmd_o.code = ST_FULL;
            state_d    = S_IDLE;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // a transfer always starts a probe read
  a_accept_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_RD))
    else $error("accepted item did not start a probe");

  // no result is produced during the clearing pass
  a_clear_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear_en |-> !cmd_o.fin && !cmd_o.ins && !cmd_o.load)
    else $error("item activity during clearing pass");

endmodule

`default_nettype wire

/* hdl/open_addressing_hash_table_unit.sv */
`default_nettype none

// Key/value store with open addressing: the home slot is key[4 +: log2(TABLE_DEPTH)]
// and collisions step by 39 slots modulo the table size. Issue an operation
// with start while busy is low; kind_i selects insert (0) or search (1). Each
// operation returns one result, shown for exactly one cycle with done_o high;
// the receiver cannot stall it, so it must be taken in that cycle. After reset
// busy stays high while every slot of the key store is cleared. An operation
// goes through a read state and then a compare state for each slot it visits;
// an insert rejected for a zero key or a more than half full table finishes in
// the first read state. Each probe is a registered read of the key store, which
// has one write port, followed by a compare. busy drops in the cycle done_o is
// shown, so the next transfer may happen then. Inserts never check for
// duplicates; a search returns the earliest matching pair on the probe chain.
module open_addressing_hash_table_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire         kind_i,
  input  wire  [31:0] key_i,
  input  wire  [31:0] value_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] found_value_o
);
  import oaht_pkg::*;

  oaht_cmd_t  cmd;
  oaht_stat_t stat;

  oaht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  oaht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_value_o (found_value_o)
  );

endmodule

`default_nettype wire

/* test/oaht_checker.sv */
`timescale 1ns / 100ps

module oaht_checker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  input  wire         busy,
  input  wire         kind_i,
  input  wire  [31:0] key_i,
  input  wire  [31:0] value_i,
  input  wire         done_i,
  input  wire  [2:0]  status_i,
  input  wire  [31:0] found_value_i,
  output int          fail_count_o,
  output int          outstanding_o
);
  import oaht_pkg::*;

  localparam int unsigned SlotBits = $clog2(TABLE_DEPTH);

  typedef struct packed {
    status_e     status;
    logic [31:0] found_value;
  } answer_t;

  logic [31:0] slot_key [TABLE_DEPTH];
  logic [31:0] slot_val [TABLE_DEPTH];
  int unsigned entry_count;
  answer_t     answer_q [$];
  int          fails = 0;
  int          pending = 0;

  // walks the probe chain of the shadow table and applies the operation
  function automatic answer_t apply_op(input logic kind, input logic [31:0] k,
                                       input logic [31:0] v);
    answer_t               ans;
    logic [SlotBits-1:0]   slot;
    logic                  hit;
    int unsigned           n;
    ans.status      = ST_NOT_FOUND;
    ans.found_value = '0;
    slot            = k[HomeShift +: SlotBits];
    hit             = 1'b0;
    if (kind == KIND_INSERT) begin
      if (k == '0) begin
        ans.status = ST_ZERO_KEY;
      end else if (entry_count * 2 > TABLE_DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        ans.status = ST_FULL;
        for (n = 0; n < TABLE_DEPTH && !hit; n++) begin
          if (slot_key[slot] == '0) begin
            slot_key[slot] = k;
            slot_val[slot] = v;
            entry_count++;
            ans.status = ST_INSERTED;
            hit = 1'b1;
          end else begin
            slot = slot + SlotBits'(ProbeStride);
          end
        end
      end
    end else begin
      for (n = 0; n < TABLE_DEPTH && !hit; n++) begin
        if (slot_key[slot] == '0) begin
          hit = 1'b1;
        end else if (slot_key[slot] == k) begin
          ans.status      = ST_FOUND;
          ans.found_value = slot_val[slot];
          hit = 1'b1;
        end else begin
          slot = slot + SlotBits'(ProbeStride);
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    int      i;
    if (!rst_ni) begin
      for (i = 0; i < TABLE_DEPTH; i++) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
      entry_count = 0;
      answer_q.delete();
    end else begin
      // result first: a new transfer may land on the same edge
      if (done_i === 1'b1) begin
        if (answer_q.size() == 0) begin
          $error("result with no operation pending: status %0d, found_value %h",
                 status_i, found_value_i);
          fails++;
        end else begin
          want = answer_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fails++;
          end
          if (found_value_i !== want.found_value) begin
            $error("found_value: expected %h, got %h", want.found_value, found_value_i);
            fails++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        answer_q.push_back(apply_op(kind_i, key_i, value_i));
      end
    end
    pending = answer_q.size();
  end

  assign fail_count_o  = fails;
  assign outstanding_o = pending;

endmodule

/* test/tb_open_addressing_hash_table_unit.sv */
`timescale 1ns / 100ps

module tb_open_addressing_hash_table_unit;
  import oaht_pkg::*;

  localparam int unsigned TableDepth  = 1024;
  localparam int unsigned RandomItems = 630;
  localparam int unsigned CalmTail    = 60;
  localparam int unsigned CycleLimit  = 5_000_000;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        start    = 1'b0;
  logic        op_kind  = KIND_INSERT;
  logic [31:0] op_key   = '0;
  logic [31:0] op_value = '0;
  wire         busy;
  wire         done;
  wire  [2:0]  status;
  wire  [31:0] found_value;
  int          fail_count;
  int          outstanding;
  int unsigned cycle_count = 0;
  logic [31:0] stored_keys [$];

  initial begin
    forever #2 clk = ~clk;
  end

  open_addressing_hash_table_unit #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .kind_i       (op_kind),
    .key_i        (op_key),
    .value_i      (op_value),
    .done_o       (done),
    .status_o     (status),
    .found_value_o(found_value)
  );

  oaht_checker #(
    .TABLE_DEPTH(TableDepth)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .kind_i       (op_kind),
    .key_i        (op_key),
    .value_i      (op_value),
    .done_i       (done),
    .status_i     (status),
    .found_value_i(found_value),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // returns at the edge that completes the transfer
  task automatic issue(input logic kind, input logic [31:0] k, input logic [31:0] v);
    start    <= 1'b1;
    op_kind  <= kind;
    op_key   <= k;
    op_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    if (kind == KIND_INSERT && k != '0) stored_keys.push_back(k);
  endtask

  task automatic pause(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // mostly random keys, some piled onto a few home slots to build long chains
  function automatic logic [31:0] fresh_key();
    int unsigned r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    k = $urandom;
    if (r < 3) begin
      k = '0;
    end else if (r < 28) begin
      k[13:4] = 10'($urandom_range(0, 3) * 97);
    end
    return k;
  endfunction

  function automatic logic [31:0] lookup_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55 && stored_keys.size() > 0) begin
      return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    end
    if (r < 60) return '0;
    return fresh_key();
  endfunction

  initial begin
    int unsigned i;
    int unsigned insert_pct;
    logic        gaps_on;
    gaps_on = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, zero key, extremes
    issue(KIND_SEARCH, 32'h1234_5670, 32'h0000_0000);
    issue(KIND_INSERT, 32'h0000_0000, 32'hDEAD_BEEF);
    issue(KIND_SEARCH, 32'h0000_0000, 32'h0000_0000);
    issue(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(KIND_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    pause(3);
    // collisions on home slot zero
    issue(KIND_INSERT, 32'h0000_0001, 32'h0000_0000);
    issue(KIND_INSERT, 32'h8000_0001, 32'h0000_0001);
    issue(KIND_INSERT, 32'h0000_000F, 32'h5555_5555);
    issue(KIND_SEARCH, 32'h8000_0001, 32'hFFFF_FFFF);
    issue(KIND_SEARCH, 32'h0000_000F, 32'h0000_0000);
    // duplicate key: the earlier pair must win
    issue(KIND_INSERT, 32'h8000_0001, 32'hAAAA_AAAA);
    issue(KIND_SEARCH, 32'h8000_0001, 32'h0000_0000);
    pause(1);
    issue(KIND_SEARCH, 32'h4000_0001, 32'h0000_0000);
    issue(KIND_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
    // home slot one stride on, already taken by the chain above
    issue(KIND_INSERT, 32'h0000_0275, 32'h0F0F_0F0F);
    issue(KIND_SEARCH, 32'h0000_0275, 32'h0000_0000);
    issue(KIND_INSERT, 32'h0000_0010, 32'hF0F0_F0F0);
    issue(KIND_SEARCH, 32'h0000_0010, 32'h1234_5678);
    issue(KIND_SEARCH, 32'hFFFF_FFF0, 32'h0000_0000);

    // insert heavy so the half-full limit is reached, an even mix at the end
    for (i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) gaps_on = 1'($urandom_range(0, 1));
      if (i < RandomItems - CalmTail) begin
        insert_pct = 92;
        if (gaps_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 17));
      end else begin
        insert_pct = 50;
      end
      if ($urandom_range(0, 99) < insert_pct) begin
        issue(KIND_INSERT, fresh_key(), $urandom);
      end else begin
        issue(KIND_SEARCH, lookup_key(), $urandom);
      end
    end
    start <= 1'b0;

    // let the last transfer show up in the checker before waiting on it
    @(posedge clk);
    wait (outstanding == 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
